// ----- rtl/btmx_pkg.sv -----
// types and constants shared by the binary trie min-xor multiset unit
// no dependencies
package btmx_pkg;

	localparam int KEY_BITS = 31;
	localparam int LVL_W = 5;

	typedef enum logic [1:0] {
		K_INSERT,
		K_REMOVE,
		K_QUERY,
		K_IGNORE
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_NO_SPACE,
		ST_NOT_FOUND
	} status_t;

	typedef struct packed {
		kind_t kind;
		logic [KEY_BITS-1:0] key_value;
	} item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] min_xor;
		status_t status;
	} result_t;

	// memory and free stack commands from the controller
	typedef struct packed {
		logic link_rd;
		logic link_wr;
		logic cnt_rd;
		logic cnt_wr;
		logic push;
		logic pop;
	} mem_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_LK,
		S_INS_CNT,
		S_INS_CHK,
		S_I2_LK,
		S_I2_INC,
		S_I2_POP,
		S_I2_LEAF,
		S_RM_LK,
		S_RM2_LK,
		S_RM2_DEC,
		S_RM2_FREE,
		S_QRY_LK
	} ctrl_state_t;

endpackage

// ----- rtl/btmx_node_mem.sv -----
// trie node storage: link pair memory, count memory, root links in flops
// depends on btmx_pkg
module btmx_node_mem #(
	parameter int MAX_NODES = 32768,
	parameter int COUNT_BITS = 16,
	localparam int NW = $clog2(MAX_NODES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  btmx_pkg::mem_cmd_t     cmd,
	input  logic [NW-1:0]          link_rd_addr,
	input  logic [NW-1:0]          link_wr_addr,
	input  logic [2*NW-1:0]        link_wr_data,
	input  logic [NW-1:0]          cnt_rd_addr,
	input  logic [NW-1:0]          cnt_wr_addr,
	input  logic [COUNT_BITS-1:0]  cnt_wr_data,
	output logic [2*NW-1:0]        link_rd_data,
	output logic [COUNT_BITS-1:0]  cnt_rd_data,
	output logic                   root_empty
);
	import btmx_pkg::*;

	logic [2*NW-1:0] link_mem [MAX_NODES];
	logic [COUNT_BITS-1:0] cnt_mem [MAX_NODES];
	logic [2*NW-1:0] link_q;
	logic [2*NW-1:0] root_q;
	logic rd_root_q;

	// link pair memory, {one, zero}; the root lives in flops
	always_ff @(posedge clk) begin
		if (cmd.link_wr && link_wr_addr != '0) begin
			link_mem[link_wr_addr] <= link_wr_data;
		end
		if (cmd.link_rd) begin
			link_q <= link_mem[link_rd_addr];
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (cmd.cnt_wr) begin
			cnt_mem[cnt_wr_addr] <= cnt_wr_data;
		end
		if (cmd.cnt_rd) begin
			cnt_rd_data <= cnt_mem[cnt_rd_addr];
		end
	end

	// root links and read source select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			rd_root_q <= 1'b0;
		end else begin
			if (cmd.link_wr && link_wr_addr == '0) begin
				root_q <= link_wr_data;
			end
			if (cmd.link_rd) begin
				rd_root_q <= (link_rd_addr == '0);
			end
		end
	end

	assign link_rd_data = rd_root_q ? root_q : link_q;
	assign root_empty = (root_q == '0);

endmodule

// ----- rtl/btmx_free_stack.sv -----
// free node stack; entries never written read as their reset contents
// depends on btmx_pkg
module btmx_free_stack #(
	parameter int MAX_NODES = 32768,
	localparam int NW = $clog2(MAX_NODES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  btmx_pkg::mem_cmd_t cmd,
	input  logic [NW-1:0]      push_data,
	output logic [NW-1:0]      free_top,
	output logic [NW-1:0]      pop_data
);
	import btmx_pkg::*;

	logic [NW-1:0] stack_mem [MAX_NODES];
	logic [NW-1:0] top_q;
	logic [NW:0] low_mark_q;
	logic [NW-1:0] rd_q;
	logic [NW-1:0] addr_q;
	logic orig_q;
	logic [NW-1:0] pop_addr;

	assign pop_addr = top_q - NW'(1);

	// stack storage
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[top_q] <= push_data;
		end
		if (cmd.pop) begin
			rd_q <= stack_mem[pop_addr];
			addr_q <= pop_addr;
		end
	end

	// top pointer and lowest slot ever written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= NW'(MAX_NODES - 1);
			low_mark_q <= (NW+1)'(MAX_NODES);
			orig_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				top_q <= top_q + NW'(1);
				if ({1'b0, top_q} < low_mark_q) begin
					low_mark_q <= {1'b0, top_q};
				end
			end else if (cmd.pop) begin
				top_q <= pop_addr;
				orig_q <= ({1'b0, pop_addr} < low_mark_q);
			end
		end
	end

	// slot p starts out holding node MAX_NODES-1-p
	assign pop_data = orig_q ? (NW'(MAX_NODES - 1) - addr_q) : rd_q;
	assign free_top = top_q;

endmodule

// ----- rtl/btmx_ctrl.sv -----
// controller: walks the trie one level at a time and issues memory commands
// depends on btmx_pkg
module btmx_ctrl #(
	parameter int MAX_NODES = 32768,
	parameter int COUNT_BITS = 16,
	localparam int NW = $clog2(MAX_NODES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  btmx_pkg::item_t       item,
	output logic                  busy,
	output logic                  done,
	output btmx_pkg::result_t     result,
	output btmx_pkg::mem_cmd_t    cmd,
	output logic [NW-1:0]         link_rd_addr,
	output logic [NW-1:0]         link_wr_addr,
	output logic [2*NW-1:0]       link_wr_data,
	output logic [NW-1:0]         cnt_rd_addr,
	output logic [NW-1:0]         cnt_wr_addr,
	output logic [COUNT_BITS-1:0] cnt_wr_data,
	output logic [NW-1:0]         push_data,
	input  logic [2*NW-1:0]       link_rd_data,
	input  logic [COUNT_BITS-1:0] cnt_rd_data,
	input  logic                  root_empty,
	input  logic [NW-1:0]         free_top,
	input  logic [NW-1:0]         pop_data
);
	import btmx_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [KEY_BITS-1:0] key_q;
	logic [LVL_W-1:0] level_q;
	logic [NW-1:0] node_q;
	logic [NW-1:0] child_q;
	logic [2*NW-1:0] pair_q;
	logic [KEY_BITS-1:0] acc_q;
	logic [LVL_W:0] needed_q;
	logic done_q;
	result_t result_q;

	logic accept;
	logic bit_cur, lvl_zero, no_room, cnt_full;
	logic [NW-1:0] rd_zero, rd_one, c_sel, c_oth, c_nxt, c_eff;
	logic [KEY_BITS-1:0] acc_set, acc_n;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic [2*NW-1:0] pair_clr, pair_ins;
	logic fin;
	status_t fin_status;
	logic [KEY_BITS-1:0] fin_xor;

	// per-level decode of the link pair just read
	assign accept = start && (state_q == S_IDLE);
	assign bit_cur = key_q[level_q];
	assign lvl_zero = (level_q == '0);
	assign rd_zero = link_rd_data[NW-1:0];
	assign rd_one = link_rd_data[2*NW-1:NW];
	assign c_sel = bit_cur ? rd_one : rd_zero;
	assign c_oth = bit_cur ? rd_zero : rd_one;
	// while freeing, level_q already names the bit under the dead node
	assign c_nxt = c_sel;
	assign c_eff = (c_sel != '0) ? c_sel : c_oth;
	assign acc_set = acc_q | (KEY_BITS'(1) << level_q);
	assign acc_n = (c_sel != '0) ? acc_q : acc_set;
	assign cnt_dec = cnt_rd_data - COUNT_BITS'(1);
	assign cnt_full = &cnt_rd_data;
	assign no_room = {{NW{1'b0}}, needed_q} > {{(LVL_W+1){1'b0}}, free_top};
	assign pair_clr = bit_cur ? {{NW{1'b0}}, pair_q[NW-1:0]} : {pair_q[2*NW-1:NW], {NW{1'b0}}};
	assign pair_ins = bit_cur ? {pop_data, pair_q[NW-1:0]} : {pair_q[2*NW-1:NW], pop_data};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (item.kind)
						K_INSERT: state_d = S_INS_LK;
						K_REMOVE: state_d = S_RM_LK;
						K_QUERY: state_d = root_empty ? S_IDLE : S_QRY_LK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS_LK: state_d = (c_sel == '0) ? S_INS_CHK : S_INS_CNT;
			S_INS_CNT: begin
				if (cnt_full) state_d = S_IDLE;
				else if (lvl_zero) state_d = S_INS_CHK;
				else state_d = S_INS_LK;
			end
			S_INS_CHK: state_d = no_room ? S_IDLE : S_I2_LK;
			S_I2_LK: state_d = (c_sel == '0) ? S_I2_POP : S_I2_INC;
			S_I2_INC: state_d = lvl_zero ? S_IDLE : S_I2_LK;
			S_I2_POP: state_d = lvl_zero ? S_I2_LEAF : S_I2_POP;
			S_I2_LEAF: state_d = S_IDLE;
			S_RM_LK: begin
				if (c_sel == '0) state_d = S_IDLE;
				else if (lvl_zero) state_d = S_RM2_LK;
				else state_d = S_RM_LK;
			end
			S_RM2_LK: state_d = S_RM2_DEC;
			S_RM2_DEC: begin
				if (lvl_zero) state_d = S_IDLE;
				else if (cnt_dec == '0) state_d = S_RM2_FREE;
				else state_d = S_RM2_LK;
			end
			S_RM2_FREE: begin
				if (c_nxt == '0 || lvl_zero) state_d = S_IDLE;
			end
			S_QRY_LK: begin
				if ((c_sel == '0 && c_oth == '0) || lvl_zero) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory commands and finishing word
	always_comb begin
		cmd = '0;
		link_rd_addr = '0;
		link_wr_addr = node_q;
		link_wr_data = '0;
		cnt_rd_addr = c_sel;
		cnt_wr_addr = node_q;
		cnt_wr_data = '0;
		push_data = child_q;
		fin = 1'b0;
		fin_status = ST_OK;
		fin_xor = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (item.kind)
						K_INSERT, K_REMOVE: cmd.link_rd = 1'b1;
						K_QUERY: begin
							if (root_empty) begin
								fin = 1'b1;
								fin_status = ST_EMPTY;
							end else begin
								cmd.link_rd = 1'b1;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_INS_LK: cmd.cnt_rd = (c_sel != '0);
			S_INS_CNT: begin
				if (cnt_full) begin
					fin = 1'b1;
					fin_status = ST_NO_SPACE;
				end else if (!lvl_zero) begin
					cmd.link_rd = 1'b1;
					link_rd_addr = node_q;
				end
			end
			S_INS_CHK: begin
				if (no_room) begin
					fin = 1'b1;
					fin_status = ST_NO_SPACE;
				end else begin
					cmd.link_rd = 1'b1;
				end
			end
			S_I2_LK: begin
				if (c_sel == '0) cmd.pop = 1'b1;
				else cmd.cnt_rd = 1'b1;
			end
			S_I2_INC: begin
				cmd.cnt_wr = 1'b1;
				cnt_wr_data = cnt_rd_data + COUNT_BITS'(1);
				if (lvl_zero) begin
					fin = 1'b1;
				end else begin
					cmd.link_rd = 1'b1;
					link_rd_addr = node_q;
				end
			end
			S_I2_POP: begin
				// hook the fresh node under its parent, start its count at one
				cmd.link_wr = 1'b1;
				link_wr_data = pair_ins;
				cmd.cnt_wr = 1'b1;
				cnt_wr_addr = pop_data;
				cnt_wr_data = COUNT_BITS'(1);
				cmd.pop = !lvl_zero;
			end
			S_I2_LEAF: begin
				cmd.link_wr = 1'b1;
				fin = 1'b1;
			end
			S_RM_LK: begin
				if (c_sel == '0) begin
					fin = 1'b1;
					fin_status = ST_NOT_FOUND;
				end else begin
					cmd.link_rd = 1'b1;
					link_rd_addr = lvl_zero ? '0 : c_sel;
				end
			end
			S_RM2_LK: cmd.cnt_rd = 1'b1;
			S_RM2_DEC: begin
				cmd.cnt_wr = 1'b1;
				cnt_wr_addr = child_q;
				cnt_wr_data = cnt_dec;
				if (cnt_dec == '0) begin
					// cut the path and free the first dead node
					cmd.link_wr = 1'b1;
					link_wr_data = pair_clr;
					cmd.push = 1'b1;
				end
				if (lvl_zero) begin
					fin = 1'b1;
				end else begin
					cmd.link_rd = 1'b1;
					link_rd_addr = child_q;
				end
			end
			S_RM2_FREE: begin
				if (c_nxt == '0) begin
					fin = 1'b1;
				end else begin
					cmd.push = 1'b1;
					push_data = c_nxt;
					if (lvl_zero) begin
						fin = 1'b1;
					end else begin
						cmd.link_rd = 1'b1;
						link_rd_addr = c_nxt;
					end
				end
			end
			S_QRY_LK: begin
				if ((c_sel == '0 && c_oth == '0) || lvl_zero) begin
					fin = 1'b1;
					fin_xor = acc_n;
				end else begin
					cmd.link_rd = 1'b1;
					link_rd_addr = c_eff;
				end
			end
			default: ;
		endcase
	end

	// walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q <= item.key_value;
					level_q <= LVL_W'(KEY_BITS - 1);
					node_q <= '0;
					acc_q <= '0;
				end
			end
			S_INS_LK: begin
				if (c_sel == '0) needed_q <= {1'b0, level_q} + (LVL_W+1)'(1);
				else node_q <= c_sel;
			end
			S_INS_CNT: begin
				if (lvl_zero) needed_q <= '0;
				else level_q <= level_q - LVL_W'(1);
			end
			S_INS_CHK: begin
				node_q <= '0;
				level_q <= LVL_W'(KEY_BITS - 1);
			end
			S_I2_LK: begin
				pair_q <= link_rd_data;
				if (c_sel != '0) node_q <= c_sel;
			end
			S_I2_INC: level_q <= level_q - LVL_W'(1);
			S_I2_POP: begin
				node_q <= pop_data;
				pair_q <= '0;
				level_q <= level_q - LVL_W'(1);
			end
			S_RM_LK: begin
				if (lvl_zero) begin
					level_q <= LVL_W'(KEY_BITS - 1);
					node_q <= '0;
				end else begin
					level_q <= level_q - LVL_W'(1);
				end
			end
			S_RM2_LK: begin
				pair_q <= link_rd_data;
				child_q <= c_sel;
			end
			S_RM2_DEC: begin
				if (cnt_dec != '0) node_q <= child_q;
				level_q <= level_q - LVL_W'(1);
			end
			S_RM2_FREE: begin
				child_q <= c_nxt;
				level_q <= level_q - LVL_W'(1);
			end
			S_QRY_LK: begin
				acc_q <= acc_n;
				node_q <= c_eff;
				level_q <= level_q - LVL_W'(1);
			end
			default: ;
		endcase
		if (fin) begin
			result_q <= '{min_xor: fin_xor, status: fin_status};
		end
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= fin;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

endmodule

// ----- rtl/binary_trie_min_xor_multiset_unit.sv -----
// top level: multiset of 31-bit keys in a binary trie, min-xor query
// depends on btmx_pkg, btmx_ctrl, btmx_node_mem, btmx_free_stack
//
// channel   direction  handshake                       word
// command   in         start && !busy                  item   (kind, key_value)
// result    out        done, one cycle, no back-pressure result (min_xor, status)
//
// query: S_QRY_LK walks one trie level per visit, down to level zero or a dead end
// remove: S_RM_LK finds the key one level at a time, then S_RM2_LK and
//   S_RM2_DEC update the count on each level, and S_RM2_FREE frees
//   one node per visit once a count drops to zero
// insert: S_INS_LK and S_INS_CNT check the counts on the existing levels,
//   S_INS_CHK checks for room, then S_I2_LK and S_I2_INC raise the counts
//   on the existing levels and S_I2_POP adds each new node before S_I2_LEAF
// reset clears the root links and the free stack pointers at once, no sweep
// done is the finishing word; a new word may start in the cycle it shows
module binary_trie_min_xor_multiset_unit #(
	parameter int MAX_NODES = 32768,
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  btmx_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output btmx_pkg::result_t result
);
	import btmx_pkg::*;

	localparam int NW = $clog2(MAX_NODES);

	mem_cmd_t cmd;
	logic [NW-1:0] link_rd_addr, link_wr_addr, cnt_rd_addr, cnt_wr_addr;
	logic [2*NW-1:0] link_wr_data, link_rd_data;
	logic [COUNT_BITS-1:0] cnt_wr_data, cnt_rd_data;
	logic [NW-1:0] push_data, free_top, pop_data;
	logic root_empty;

	// sequencer
	btmx_ctrl #(.MAX_NODES(MAX_NODES), .COUNT_BITS(COUNT_BITS)) u_ctrl (
		.clk, .arst_n, .start, .item, .busy, .done, .result, .cmd,
		.link_rd_addr, .link_wr_addr, .link_wr_data,
		.cnt_rd_addr, .cnt_wr_addr, .cnt_wr_data, .push_data,
		.link_rd_data, .cnt_rd_data, .root_empty, .free_top, .pop_data
	);

	// node storage
	btmx_node_mem #(.MAX_NODES(MAX_NODES), .COUNT_BITS(COUNT_BITS)) u_node_mem (
		.clk, .arst_n, .cmd,
		.link_rd_addr, .link_wr_addr, .link_wr_data,
		.cnt_rd_addr, .cnt_wr_addr, .cnt_wr_data,
		.link_rd_data, .cnt_rd_data, .root_empty
	);

	// free node stack
	btmx_free_stack #(.MAX_NODES(MAX_NODES)) u_free_stack (
		.clk, .arst_n, .cmd, .push_data, .free_top, .pop_data
	);

	// a walk always ends with its result word
	a_end_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("walk ended without result word");

	// min_xor is zero unless the word is a good query
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.min_xor == '0))
		else $error("failed word carries nonzero min_xor");

	// insert and remove always walk the trie
	a_walk_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.kind == K_INSERT || item.kind == K_REMOVE)) |=> busy)
		else $error("insert or remove did not start a walk");

endmodule
